FILE: hw/rtl/pmt_pkg.sv
package pmt_pkg;

   localparam int CoordWidth = 32;
   localparam int SpeedWidth = 31;
   localparam int DiffWidth  = 33;
   localparam int SqWidth    = 66;

   typedef struct packed {
      logic                         func;
      logic signed [CoordWidth-1:0] target_x;
      logic signed [CoordWidth-1:0] target_y;
      logic        [SpeedWidth-1:0] step_speed;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic        [CoordWidth-1:0] magnitude;
      logic                         arrived;
   } rsp_type;

   localparam logic FuncSet  = 1'b0;
   localparam logic FuncMove = 1'b1;

   function automatic logic [DiffWidth-1:0] abs33(input logic [DiffWidth-1:0] v);
      logic [DiffWidth-1:0] r;
      r = v[DiffWidth-1] ? (~v + 33'd1) : v;
      return r;
   endfunction

   // cur +/- mag, clamped to the signed 32-bit range
   function automatic logic [CoordWidth-1:0] step_sat(input logic [CoordWidth-1:0] cur,
                                                      input logic                  neg,
                                                      input logic [DiffWidth-1:0]  mag);
      logic [DiffWidth:0] ext;
      logic [DiffWidth:0] m;
      logic [DiffWidth:0] s;
      logic [CoordWidth-1:0] r;
      ext = {{2{cur[CoordWidth-1]}}, cur};
      m   = {1'b0, mag};
      s   = neg ? (ext - m) : (ext + m);
      if (s[DiffWidth] != s[DiffWidth-1] || s[DiffWidth] != s[CoordWidth-1]) begin
         r = s[DiffWidth] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         r = s[CoordWidth-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/pmt_mul.sv
module pmt_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] a,
   input  logic [32:0] b,
   output logic [65:0] prod,
   output logic        done
);
   import pmt_pkg::*;

   localparam logic [5:0] Steps = 6'd33;

   logic [DiffWidth-1:0] a_ff;
   logic [DiffWidth-1:0] hi_ff;
   logic [DiffWidth-1:0] lo_ff;
   logic [5:0]           cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DiffWidth:0]   sum_in;

   // one multiplier bit per cycle, add then shift right
   assign sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            a_ff    <= a;
            hi_ff   <= '0;
            lo_ff   <= b;
            cnt_ff  <= Steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            hi_ff  <= sum_in[DiffWidth:1];
            lo_ff  <= {sum_in[0], lo_ff[DiffWidth-1:1]};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign prod = {hi_ff, lo_ff};
   assign done = done_ff;

endmodule

FILE: hw/rtl/pmt_sqrt.sv
module pmt_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] radicand,
   output logic [32:0] root,
   output logic        done
);
   import pmt_pkg::*;

   localparam logic [5:0] Steps = 6'd33;

   logic [SqWidth-1:0]   rad_ff;
   logic [35:0]          rem_ff;
   logic [DiffWidth-1:0] root_ff;
   logic [5:0]           cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [35:0]          pair_rem;
   logic [35:0]          trial;
   logic                 fits;

   // one root bit per cycle from the next two radicand bits
   assign pair_rem = {rem_ff[33:0], rad_ff[SqWidth-1:SqWidth-2]};
   assign trial    = {1'b0, root_ff, 2'b01};
   assign fits     = pair_rem >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 6'd1);
         if (start) begin
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= Steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[SqWidth-3:0], 2'b00};
            rem_ff  <= fits ? (pair_rem - trial) : pair_rem;
            root_ff <= {root_ff[DiffWidth-2:0], fits};
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

FILE: hw/rtl/pmt_div.sv
module pmt_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic [32:0] quotient,
   output logic        done
);
   import pmt_pkg::*;

   localparam logic [6:0] Steps = 7'd64;

   logic [63:0]          dvd_ff;
   logic [DiffWidth-1:0] rem_ff;
   logic [DiffWidth-1:0] dvs_ff;
   logic [6:0]           cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DiffWidth:0]   part;
   logic [DiffWidth:0]   diff;
   logic                 fits;

   // restoring division, quotient bits shift in behind the dividend
   assign part = {rem_ff, dvd_ff[63]};
   assign diff = part - {1'b0, dvs_ff};
   assign fits = part >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == 7'd1);
         if (start) begin
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= Steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DiffWidth-1:0] : part[DiffWidth-1:0];
            dvd_ff <= {dvd_ff[62:0], fits};
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign quotient = dvd_ff[DiffWidth-1:0];
   assign done     = done_ff;

endmodule

FILE: hw/rtl/point_move_toward_target.sv
// channel | direction | ports                         | payload
// req     | in        | req_valid, req_stall, req_data | pmt_pkg::req_type
// rsp     | out       | rsp_valid, rsp_stall, rsp_data | pmt_pkg::rsp_type
//
// one item at a time; squarer, root and divider shift one bit per cycle
// set item: two squarings and a root
// two-axis move: four squarings, two roots, two products and two
// divisions; snap or single-axis move: four squarings and two roots
// reset clears the position to zero; a held result stalls only the last step
module point_move_toward_target (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pmt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pmt_pkg::rsp_type rsp_data
);
   import pmt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ1, ST_SQ2, ST_ROOT, ST_MULX, ST_DIVX, ST_MULY, ST_DIVY,
      ST_MSQ1, ST_MSQ2, ST_MROOT, ST_OUT
   } state_type;

   state_type            state_ff;
   logic [CoordWidth-1:0] cur_x_ff, cur_y_ff, tx_ff, ty_ff, mag_ff;
   logic [SpeedWidth-1:0] speed_ff;
   logic                  func_ff;
   logic [DiffWidth-1:0]  dx_ff, dy_ff, dist_ff, qx_ff;
   logic [SqWidth-1:0]    sum_ff;
   logic [63:0]           prod_ff;
   logic                  mul_start_ff, sqrt_start_ff, div_start_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [DiffWidth-1:0]  mul_a, dx_abs, dy_abs, speed_ext;
   logic [SqWidth-1:0]    mul_prod;
   logic                  mul_done, sqrt_done, div_done;
   logic [DiffWidth-1:0]  sqrt_root, div_q;

   assign dx_abs    = abs33(dx_ff);
   assign dy_abs    = abs33(dy_ff);
   assign speed_ext = {2'b00, speed_ff};

   logic [DiffWidth-1:0] mul_b;
   always_comb begin
      unique case (state_ff)
         ST_SQ1:  begin mul_a = dx_abs; mul_b = dx_abs; end
         ST_SQ2:  begin mul_a = dy_abs; mul_b = dy_abs; end
         ST_MULX: begin mul_a = dx_abs; mul_b = speed_ext; end
         ST_MULY: begin mul_a = dy_abs; mul_b = speed_ext; end
         ST_MSQ1: begin
            mul_a = abs33({cur_x_ff[CoordWidth-1], cur_x_ff});
            mul_b = mul_a;
         end
         ST_MSQ2: begin
            mul_a = abs33({cur_y_ff[CoordWidth-1], cur_y_ff});
            mul_b = mul_a;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   pmt_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start_ff),
      .a (mul_a), .b (mul_b), .prod (mul_prod), .done (mul_done)
   );

   pmt_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sqrt_start_ff),
      .radicand (sum_ff), .root (sqrt_root), .done (sqrt_done)
   );

   pmt_div u_div (
      .clock (clock), .reset (reset), .start (div_start_ff),
      .dividend (prod_ff), .divisor (dist_ff), .quotient (div_q), .done (div_done)
   );

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         mul_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mul_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  tx_ff        <= req_data.target_x;
                  ty_ff        <= req_data.target_y;
                  speed_ff     <= req_data.step_speed;
                  func_ff      <= req_data.func;
                  dx_ff        <= {req_data.target_x[CoordWidth-1], req_data.target_x}
                                - {cur_x_ff[CoordWidth-1], cur_x_ff};
                  dy_ff        <= {req_data.target_y[CoordWidth-1], req_data.target_y}
                                - {cur_y_ff[CoordWidth-1], cur_y_ff};
                  mul_start_ff <= 1'b1;
                  if (req_data.func == FuncMove) begin
                     state_ff <= ST_SQ1;
                  end else begin
                     cur_x_ff <= req_data.target_x;
                     cur_y_ff <= req_data.target_y;
                     state_ff <= ST_MSQ1;
                  end
               end
            end
            ST_SQ1: begin
               if (mul_done) begin
                  sum_ff       <= mul_prod;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_SQ2;
               end
            end
            ST_SQ2: begin
               if (mul_done) begin
                  sum_ff        <= sum_ff + mul_prod;
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (sqrt_done) begin
                  dist_ff      <= sqrt_root;
                  mul_start_ff <= 1'b1;
                  priority if (sqrt_root <= speed_ext) begin
                     cur_x_ff <= tx_ff;
                     cur_y_ff <= ty_ff;
                     state_ff <= ST_MSQ1;
                  end else if (dx_ff == '0) begin
                     cur_y_ff <= step_sat(cur_y_ff, dy_ff[DiffWidth-1], speed_ext);
                     state_ff <= ST_MSQ1;
                  end else if (dy_ff == '0) begin
                     cur_x_ff <= step_sat(cur_x_ff, dx_ff[DiffWidth-1], speed_ext);
                     state_ff <= ST_MSQ1;
                  end else begin
                     state_ff <= ST_MULX;
                  end
               end
            end
            ST_MULX: begin
               if (mul_done) begin
                  prod_ff      <= mul_prod[63:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIVX;
               end
            end
            ST_DIVX: begin
               if (div_done) begin
                  qx_ff        <= div_q;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MULY;
               end
            end
            ST_MULY: begin
               if (mul_done) begin
                  prod_ff      <= mul_prod[63:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIVY;
               end
            end
            ST_DIVY: begin
               if (div_done) begin
                  cur_x_ff     <= step_sat(cur_x_ff, dx_ff[DiffWidth-1], qx_ff);
                  cur_y_ff     <= step_sat(cur_y_ff, dy_ff[DiffWidth-1], div_q);
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MSQ1;
               end
            end
            ST_MSQ1: begin
               if (mul_done) begin
                  sum_ff       <= mul_prod;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MSQ2;
               end
            end
            ST_MSQ2: begin
               if (mul_done) begin
                  sum_ff        <= sum_ff + mul_prod;
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= ST_MROOT;
               end
            end
            ST_MROOT: begin
               if (sqrt_done) begin
                  mag_ff   <= sqrt_root[CoordWidth-1:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // wait for the output register to free up
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.pos_x     <= cur_x_ff;
                  rsp_data_ff.pos_y     <= cur_y_ff;
                  rsp_data_ff.magnitude <= mag_ff;
                  rsp_data_ff.arrived   <= (cur_x_ff == tx_ff) && (cur_y_ff == ty_ff);
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> dist_ff != '0)
      else $error("division started with zero distance");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVX && div_done) |-> div_q <= dx_abs)
      else $error("x step exceeds axis difference");

   a_set_arrives: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && func_ff == FuncSet) |->
         (cur_x_ff == tx_ff && cur_y_ff == ty_ff))
      else $error("set item did not land on target");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $countones({mul_start_ff, sqrt_start_ff, div_start_ff}) <= 1)
      else $error("two arithmetic units started together");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import pmt_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   point_move_toward_target dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   req_type pending_q[$];
   rsp_type position_q[$];
   logic signed [31:0] pos_x_model;
   logic signed [31:0] pos_y_model;
   int errors;
   int sent;
   int drain_at;
   int got;
   longint cycles;

   // floor(sqrt(v)) bit by bit
   function automatic logic [33:0] root68(input logic [67:0] v);
      logic [69:0] rem;
      logic [69:0] trial;
      logic [33:0] r;
      rem = '0;
      r = '0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 2) | v[2*i +: 2];
         trial = {34'd0, r, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            r = (r << 1) | 34'd1;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

   function automatic logic [33:0] hypot(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      return root68({4'd0, ma} * {4'd0, ma} + {4'd0, mb} * {4'd0, mb});
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic rsp_type advance_position(input req_type r);
      logic signed [63:0] tx;
      logic signed [63:0] ty;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] sp;
      logic [33:0] span;
      logic [64:0] qx;
      logic [64:0] qy;
      rsp_type o;
      tx = r.target_x;
      ty = r.target_y;
      sp = {33'd0, r.step_speed};
      if (r.func == FuncSet) begin
         pos_x_model = r.target_x;
         pos_y_model = r.target_y;
      end else begin
         dx = tx - pos_x_model;
         dy = ty - pos_y_model;
         span = hypot(dx, dy);
         if (span <= {3'd0, r.step_speed}) begin
            pos_x_model = r.target_x;
            pos_y_model = r.target_y;
         end else if (dx == 0) begin
            pos_y_model = clamp32(pos_y_model + (dy > 0 ? sp : -sp));
         end else if (dy == 0) begin
            pos_x_model = clamp32(pos_x_model + (dx > 0 ? sp : -sp));
         end else begin
            qx = ({1'b0, dx < 0 ? -dx : dx} * {34'd0, r.step_speed}) / {31'd0, span};
            qy = ({1'b0, dy < 0 ? -dy : dy} * {34'd0, r.step_speed}) / {31'd0, span};
            pos_x_model = clamp32(pos_x_model + (dx < 0 ? -$signed(qx[63:0])
                                                        : $signed(qx[63:0])));
            pos_y_model = clamp32(pos_y_model + (dy < 0 ? -$signed(qy[63:0])
                                                        : $signed(qy[63:0])));
         end
      end
      o.pos_x = pos_x_model;
      o.pos_y = pos_y_model;
      o.magnitude = 32'(hypot(pos_x_model, pos_y_model));
      o.arrived = (pos_x_model == r.target_x) && (pos_y_model == r.target_y);
      return o;
   endfunction

   // mostly small coordinates, sometimes anywhere in range
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      endcase
   endfunction

   function automatic logic [30:0] pick_speed();
      case ($urandom_range(0, 4))
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, 32'h0001_0000));
         2: return 31'd0;
         default: return 31'($urandom_range(0, 32'h0010_0000));
      endcase
   endfunction

   task automatic add_item(input logic f, input logic [31:0] x, input logic [31:0] y,
                           input logic [30:0] s);
      req_type r;
      r.func = f;
      r.target_x = x;
      r.target_y = y;
      r.step_speed = s;
      pending_q.push_back(r);
   endtask

   // sender: bursts and gaps, one pause for a full drain
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            position_q.push_back(advance_position(req_data));
            sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_q.size() == 0 ||
                         (sent == drain_at && position_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // receiver: random stall pattern, one long hold-off
   int hold_left;
   int stall_mode;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         stall_mode <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (position_q.size() == 0) begin
               $display("%0t unexpected item: %p", $time, rsp_data);
               errors++;
            end else begin
               rsp_type e;
               e = position_q.pop_front();
               if (e.pos_x !== rsp_data.pos_x)
                  $display("%0t pos_x expected %h actual %h", $time, e.pos_x, rsp_data.pos_x);
               if (e.pos_y !== rsp_data.pos_y)
                  $display("%0t pos_y expected %h actual %h", $time, e.pos_y, rsp_data.pos_y);
               if (e.magnitude !== rsp_data.magnitude)
                  $display("%0t magnitude expected %h actual %h", $time, e.magnitude,
                           rsp_data.magnitude);
               if (e.arrived !== rsp_data.arrived)
                  $display("%0t arrived expected %b actual %b", $time, e.arrived,
                           rsp_data.arrived);
               if (e !== rsp_data) errors++;
            end
            got++;
            if (got == 40) hold_left <= 3000;
            if (got % 150 == 0) stall_mode <= $urandom_range(0, 2);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 6000000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   initial begin
      logic [31:0] x;
      logic [31:0] y;
      errors = 0;
      sent = 0;
      got = 0;
      cycles = 0;
      drain_at = 900;
      pos_x_model = '0;
      pos_y_model = '0;
      reset = 1'b1;
      // directed: extremes, snap, single axis, zero speed, two-axis
      add_item(FuncMove, 32'h0000_0000, 32'h0000_0000, 31'd0);
      add_item(FuncSet, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
      add_item(FuncMove, 32'h7fff_ffff, 32'h7fff_ffff, 31'h0001_0000);
      add_item(FuncMove, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      add_item(FuncMove, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      add_item(FuncMove, 32'h8000_0000, 32'h8000_0000, 31'd0);
      add_item(FuncSet, 32'h7fff_ffff, 32'h8000_0000, 31'd0);
      add_item(FuncMove, 32'h7fff_ffff, 32'h7fff_ffff, 31'h0003_0000);
      add_item(FuncMove, 32'h8000_0000, 32'h7fff_ffff, 31'h1234_5678);
      add_item(FuncSet, 32'h0000_0000, 32'h0000_0000, 31'd5);
      add_item(FuncMove, 32'h0005_0000, 32'h0000_0000, 31'h0001_0000);
      add_item(FuncMove, 32'h0000_0000, 32'h0000_0000, 31'h0001_0000);
      add_item(FuncMove, 32'h0000_0000, 32'hfffb_0000, 31'h0002_0000);
      add_item(FuncMove, 32'h0003_0000, 32'h0004_0000, 31'h0001_0000);
      add_item(FuncMove, 32'h0003_0000, 32'h0004_0000, 31'h0010_0000);
      add_item(FuncMove, 32'hfff0_0000, 32'h000c_0000, 31'h0000_0001);
      add_item(FuncMove, 32'h0000_0001, 32'h0000_0001, 31'd0);
      add_item(FuncSet, 32'hffff_ffff, 32'h0000_0001, 31'd0);
      add_item(FuncMove, 32'h0000_0001, 32'hffff_ffff, 31'd1);
      add_item(FuncMove, 32'h0000_0001, 32'hffff_ffff, 31'd3);
      for (int i = 0; i < 1880; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            add_item(FuncSet, pick_coord(), pick_coord(), 31'($urandom));
         end else begin
            // sometimes chase the same target for a second step
            x = pick_coord();
            y = ($urandom_range(0, 7) == 0) ? 32'd0 : pick_coord();
            add_item(FuncMove, x, y, pick_speed());
            if ($urandom_range(0, 2) == 0) begin
               add_item(FuncMove, x, y, pick_speed());
               i++;
            end
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_q.size() != 0 || req_valid || position_q.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
